@@ rtl/urba_pkg.sv @@
`default_nettype none

package urba_pkg;

    // Field widths
    localparam int REQ_W      = 32;
    localparam int OFFSET_W   = 32;
    localparam int ALIGNED_W  = 33;
    localparam int COUNT_W    = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    // Parameter defaults
    localparam int OFFSET_BITS_DEF = 32;
    localparam int Q_DEPTH_DEF     = 2;

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0]  REG_CAPACITY  = 1'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_ALIGNMENT = 1'd1;
    localparam logic [CFG_DATA_W-1:0] CAPACITY_RST  = 32'd65536;
    localparam logic [CFG_DATA_W-1:0] ALIGNMENT_RST = 32'd1;

    // Request kinds
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    // Input item
    typedef struct packed {
        logic             op;
        logic [REQ_W-1:0] request_bytes;
    } t_req;

    // Classified item between front and back
    typedef struct packed {
        logic                 op;
        logic [ALIGNED_W-1:0] aligned_bytes;
    } t_work;

    // Result item
    typedef struct packed {
        logic                 granted;
        logic [OFFSET_W-1:0]  offset;
        logic [ALIGNED_W-1:0] aligned_bytes;
        logic                 wrapped;
        logic                 overflow_flag;
        logic [OFFSET_W-1:0]  peak_used;
        logic [COUNT_W-1:0]   grant_count;
        logic [COUNT_W-1:0]   wrap_total;
    } t_result;

    // Front sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_PUSH = 3'b100
    } t_front_state;

endpackage

`default_nettype wire

@@ rtl/urba_fifo.sv @@
`default_nettype none

module urba_fifo
    import urba_pkg::*;
#(
    parameter type t_data = logic,
    parameter int  DEPTH  = Q_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_data i_data,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_empty,
    output t_data      o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_data           r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/urba_front.sv @@
`default_nettype none

module urba_front
    import urba_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire t_req                  i_req,
    output logic                       o_full,
    input  wire logic [CFG_DATA_W-1:0] i_alignment,
    output logic                       o_work_push,
    output t_work                      o_work,
    input  wire logic                  i_work_full
);

    localparam int STEP_W = $clog2(REQ_W);

    t_front_state       r_state;
    t_front_state       n_state;
    logic               r_op;
    logic [REQ_W-1:0]   r_req;
    logic [REQ_W-1:0]   r_shift;
    logic [REQ_W-1:0]   r_align;
    logic [REQ_W-1:0]   r_rem;
    logic [STEP_W-1:0]  r_step;
    logic [REQ_W:0]     trial;
    logic [REQ_W-1:0]   rem_next;
    logic [ALIGNED_W-1:0] pad;

    assign o_full = (r_state != S_IDLE);

    // One remainder bit per cycle: restoring step
    always_comb begin
        trial = {r_rem, r_shift[REQ_W-1]};
        if (trial >= {1'b0, r_align}) begin
            rem_next = REQ_W'(trial - {1'b0, r_align});
        end else begin
            rem_next = trial[REQ_W-1:0];
        end
    end

    // Round up: add the distance to the next multiple
    assign pad = (r_rem == '0) ? '0 : ALIGNED_W'(r_align - r_rem);

    always_comb begin
        o_work.op            = r_op;
        o_work.aligned_bytes = (r_op == OP_FRAME) ? '0 : ALIGNED_W'(r_req) + pad;
        o_work_push          = (r_state == S_PUSH) && !i_work_full;
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_push) begin
                    n_state = (i_req.op == OP_FRAME) ? S_PUSH : S_DIV;
                end
            end
            S_DIV: begin
                if (r_step == STEP_W'(REQ_W - 1)) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!i_work_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Operand and remainder registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_push) begin
            r_op    <= i_req.op;
            r_req   <= i_req.request_bytes;
            r_shift <= i_req.request_bytes;
            r_align <= (i_alignment == '0) ? REQ_W'(1) : i_alignment;
            r_rem   <= '0;
            r_step  <= '0;
        end else if (r_state == S_DIV) begin
            r_rem   <= rem_next;
            r_shift <= {r_shift[REQ_W-2:0], 1'b0};
            r_step  <= r_step + 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ rtl/urba_back.sv @@
`default_nettype none

module urba_back
    import urba_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_work_valid,
    input  wire t_work                 i_work,
    output logic                       o_work_pop,
    input  wire logic                  i_res_full,
    output logic                       o_res_push,
    output t_result                    o_res,
    input  wire logic [CFG_DATA_W-1:0] i_capacity
);

    // Compare width covers cursor plus a rounded size
    localparam int SW = ((OFFSET_BITS > ALIGNED_W) ? OFFSET_BITS : ALIGNED_W) + 1;

    logic [OFFSET_BITS-1:0] r_cursor, n_cursor;
    logic [OFFSET_BITS-1:0] r_peak, n_peak;
    logic [COUNT_W-1:0]     r_grants, n_grants;
    logic [COUNT_W-1:0]     r_wraps, n_wraps;
    logic                   r_ovf, n_ovf;

    logic          fire;
    logic [SW-1:0] cap_w, off_max, cap_eff, size_w, sum_w, end_w;
    logic          fits, wrap;

    assign fire       = i_work_valid && !i_res_full;
    assign o_work_pop = fire;
    assign o_res_push = fire;

    // Fit and wrap decisions
    always_comb begin
        cap_w   = SW'(i_capacity);
        off_max = SW'({OFFSET_BITS{1'b1}});
        cap_eff = (cap_w > off_max) ? off_max : cap_w;
        size_w  = SW'(i_work.aligned_bytes);
        sum_w   = SW'(r_cursor) + size_w;
        fits    = (cap_eff != '0) && (size_w <= cap_eff);
        wrap    = sum_w > cap_eff;
        end_w   = wrap ? size_w : sum_w;
    end

    // Next state and result
    always_comb begin
        n_cursor = r_cursor;
        n_peak   = r_peak;
        n_grants = r_grants;
        n_wraps  = r_wraps;
        n_ovf    = r_ovf;

        o_res.granted       = 1'b0;
        o_res.offset        = '0;
        o_res.aligned_bytes = '0;
        o_res.wrapped       = 1'b0;

        if (i_work.op == OP_FRAME) begin
            n_cursor = '0;
            n_peak   = '0;
            n_grants = '0;
            n_ovf    = 1'b0;
        end else begin
            o_res.aligned_bytes = i_work.aligned_bytes;
            if (!fits) begin
                n_ovf = 1'b1;
            end else begin
                o_res.granted = 1'b1;
                o_res.wrapped = wrap;
                o_res.offset  = wrap ? '0 : OFFSET_W'(r_cursor);
                n_cursor      = OFFSET_BITS'(end_w);
                if (OFFSET_BITS'(end_w) > r_peak) begin
                    n_peak = OFFSET_BITS'(end_w);
                end
                if (r_grants != '1) begin
                    n_grants = r_grants + 1'b1;
                end
                if (wrap && r_wraps != '1) begin
                    n_wraps = r_wraps + 1'b1;
                end
            end
        end

        o_res.overflow_flag = n_ovf;
        o_res.peak_used     = OFFSET_W'(n_peak);
        o_res.grant_count   = n_grants;
        o_res.wrap_total    = n_wraps;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_peak   <= '0;
            r_grants <= '0;
            r_wraps  <= '0;
            r_ovf    <= 1'b0;
        end else if (fire) begin
            r_cursor <= n_cursor;
            r_peak   <= n_peak;
            r_grants <= n_grants;
            r_wraps  <= n_wraps;
            r_ovf    <= n_ovf;
        end
    end

endmodule

`default_nettype wire

@@ rtl/upload_ring_bump_allocator_top.sv @@
// Allocate: the front accepts, runs 32 remainder steps and hands off, and takes no
// new request until it has handed off; the bit-serial alignment remainder sets this.
// Begin frame: the front accepts and hands off with no remainder steps. Hand-off waits
// while the mid queue is full; the back end then writes each result into the result queue.
// Reset (i_rst_n low, synchronous) empties both queues, clears cursor, peak,
// counters and overflow, and loads capacity 65536 and alignment 1.
`default_nettype none

module upload_ring_bump_allocator_top
    import urba_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int QUEUE_DEPTH = Q_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_push,
    input  wire t_req                  i_req,
    output logic                       o_full,
    input  wire logic                  i_pop,
    output t_result                    o_res,
    output logic                       o_empty
);

    logic [CFG_DATA_W-1:0] r_capacity;
    logic [CFG_DATA_W-1:0] r_alignment;

    logic    front_push;
    t_work   front_work;
    logic    mid_full;
    logic    mid_empty;
    t_work   mid_work;
    logic    back_pop;
    logic    res_push;
    t_result res_data;
    logic    res_full;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAPACITY_RST;
            r_alignment <= ALIGNMENT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CAPACITY:  r_capacity  <= i_cfg_data;
                REG_ALIGNMENT: r_alignment <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front: accept and round up
    urba_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_req       (i_req),
        .o_full      (o_full),
        .i_alignment (r_alignment),
        .o_work_push (front_push),
        .o_work      (front_work),
        .i_work_full (mid_full)
    );

    // Queue between front and back
    urba_fifo #(
        .t_data (t_work),
        .DEPTH  (QUEUE_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_work),
        .i_pop   (back_pop),
        .o_full  (mid_full),
        .o_empty (mid_empty),
        .o_data  (mid_work)
    );

    // Back: ring state update
    urba_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (!mid_empty),
        .i_work       (mid_work),
        .o_work_pop   (back_pop),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res        (res_data),
        .i_capacity   (r_capacity)
    );

    // Result queue
    urba_fifo #(
        .t_data (t_result),
        .DEPTH  (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_data),
        .i_pop   (i_pop),
        .o_full  (res_full),
        .o_empty (o_empty),
        .o_data  (o_res)
    );

endmodule

`default_nettype wire

@@ rtl/urba_checker.sv @@
`default_nettype none

module urba_checker
    import urba_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    i_pop,
    input wire logic    o_full,
    input wire logic    o_empty,
    input wire t_result o_res
);

    // Reset leaves both sides open and nothing waiting
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("queue state not cleared by reset");

    // A waiting result that is not taken stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_res)))
        else $error("stalled result changed");

    // No offset without a grant
    a_no_grant_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_res.granted) |-> (o_res.offset == '0 && !o_res.wrapped))
        else $error("offset or wrap shown without grant");

    // A wrap starts at zero and is counted
    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_res.wrapped) |-> (o_res.offset == '0 && o_res.wrap_total != '0))
        else $error("wrap result inconsistent");

    // A grant is counted
    a_grant_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_res.granted) |-> (o_res.grant_count != '0))
        else $error("grant not counted");

endmodule

bind upload_ring_bump_allocator_top urba_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_pop   (i_pop),
    .o_full  (o_full),
    .o_empty (o_empty),
    .o_res   (o_res)
);

`default_nettype wire

@@ tb/upload_ring_bump_allocator_top_tb.sv @@
`timescale 1ns / 1ps

module upload_ring_bump_allocator_top_tb
    import urba_pkg::*;
();

    localparam int          LATENCY_CYCLES = 40;
    localparam int          DRAIN_LIMIT    = 3000;
    localparam int          HOLD_CYCLES    = 400;
    localparam logic [63:0] OFFSET_LIMIT   = (64'd1 << OFFSET_BITS_DEF) - 64'd1;
    localparam logic [63:0] COUNT_LIMIT    = 64'hFFFF_FFFF;
    localparam logic [CFG_DATA_W-1:0] ALL_ONES = '1;

    // DUT connections
    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  push;
    t_req                  req;
    logic                  full;
    logic                  pop;
    t_result               res;
    logic                  empty;

    // Allocator state as the checker sees it
    logic [63:0] cfg_capacity;
    logic [63:0] cfg_alignment;
    logic [63:0] ring_cursor;
    logic [63:0] ring_peak;
    logic [63:0] frame_grants;
    logic [63:0] wrap_tally;
    logic        overflow_seen;

    t_result     pending_results[$];
    int          mismatch_count;
    int          results_checked;
    bit          quiet_tail;
    bit          long_hold;

    upload_ring_bump_allocator_top i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_push     (push),
        .i_req      (req),
        .o_full     (full),
        .i_pop      (pop),
        .o_res      (res),
        .o_empty    (empty)
    );

    // 12 ns clock
    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Expected result of one request; updates the allocator state
    function automatic t_result compute_allocation(input t_req item);
        t_result     outcome;
        logic [63:0] grain;
        logic [63:0] rounded;
        logic [63:0] ring_cap;
        outcome = '0;
        if (item.op == OP_FRAME) begin
            ring_cursor   = '0;
            ring_peak     = '0;
            frame_grants  = '0;
            overflow_seen = 1'b0;
        end else begin
            // zero alignment acts as one
            grain    = (cfg_alignment == 0) ? 64'd1 : cfg_alignment;
            rounded  = ((64'(item.request_bytes) + grain - 64'd1) / grain) * grain;
            ring_cap = (cfg_capacity > OFFSET_LIMIT) ? OFFSET_LIMIT : cfg_capacity;
            outcome.aligned_bytes = rounded[ALIGNED_W-1:0];
            if (ring_cap == 0 || rounded > ring_cap) begin
                overflow_seen = 1'b1;
            end else begin
                // no room after the cursor: restart at zero
                if (ring_cursor + rounded > ring_cap) begin
                    ring_cursor     = '0;
                    outcome.wrapped = 1'b1;
                    if (wrap_tally < COUNT_LIMIT) wrap_tally++;
                end
                outcome.granted = 1'b1;
                outcome.offset  = ring_cursor[OFFSET_W-1:0];
                ring_cursor     = ring_cursor + rounded;
                if (ring_cursor > ring_peak) ring_peak = ring_cursor;
                if (frame_grants < COUNT_LIMIT) frame_grants++;
            end
        end
        outcome.overflow_flag = overflow_seen;
        outcome.peak_used     = ring_peak[OFFSET_W-1:0];
        outcome.grant_count   = frame_grants[COUNT_W-1:0];
        outcome.wrap_total    = wrap_tally[COUNT_W-1:0];
        return outcome;
    endfunction

    // Random request size, mostly in reach of the ring
    function automatic logic [REQ_W-1:0] pick_request_size(input logic [63:0] ring_cap);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (ring_cap != 0 && sel < 55) return REQ_W'($urandom_range(0, 32'(ring_cap / 4)));
        if (ring_cap != 0 && sel < 80) return REQ_W'($urandom_range(0, 32'(ring_cap)));
        if (sel < 90) return REQ_W'($urandom());
        return REQ_W'($urandom_range(0, 16));
    endfunction

    // Mismatch reporting: one line per mismatch
    task automatic flag_error(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [63:0] seen,
                               input logic [63:0] want);
        if (seen !== want)
            flag_error($sformatf("result %0d %s got %0h, expected %0h",
                                 results_checked, name, seen, want));
    endtask

    // One request transfer; may leave a random gap afterwards
    task automatic send_request(input logic op, input logic [REQ_W-1:0] nbytes);
        t_req    item;
        t_result expected;
        int      gap;
        item.op            = op;
        item.request_bytes = nbytes;
        @(negedge clk);
        push <= 1'b1;
        req  <= item;
        @(posedge clk);
        while (full) @(posedge clk);
        expected = compute_allocation(item);
        pending_results.insert(pending_results.size(), expected);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Stop sending and let every outstanding result come back
    task automatic wait_idle();
        int waited;
        waited = 0;
        @(negedge clk);
        push <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", pending_results.size()));
            pending_results.delete();
        end
        repeat (LATENCY_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        if (idx == REG_CAPACITY) cfg_capacity = 64'(value);
        else cfg_alignment = 64'(value);
    endtask

    task automatic set_ring(input logic [CFG_DATA_W-1:0] cap,
                            input logic [CFG_DATA_W-1:0] align);
        wait_idle();
        write_reg(REG_CAPACITY, cap);
        write_reg(REG_ALIGNMENT, align);
    endtask

    task automatic run_random_items(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) == 0) send_request(OP_FRAME, REQ_W'($urandom()));
            else send_request(OP_ALLOC, pick_request_size(cfg_capacity));
        end
    endtask

    // Reset values: zero-size grant, exact fill, wrap, oversize, frame clear
    task automatic test_reset_settings();
        send_request(OP_ALLOC, 32'd0);
        send_request(OP_ALLOC, 32'd100);
        send_request(OP_ALLOC, 32'd65436);
        send_request(OP_ALLOC, 32'd1);
        send_request(OP_ALLOC, ALL_ONES);
        send_request(OP_FRAME, ALL_ONES);
    endtask

    // Largest capacity and alignments, rounded size needing the 33rd bit
    task automatic test_alignment_extremes();
        set_ring(ALL_ONES, ALL_ONES);
        send_request(OP_ALLOC, 32'd1);
        send_request(OP_ALLOC, 32'd0);
        send_request(OP_ALLOC, ALL_ONES);
        set_ring(ALL_ONES, 32'h8000_0000);
        send_request(OP_ALLOC, 32'h8000_0001);
        send_request(OP_ALLOC, 32'h7FFF_FFFF);
        send_request(OP_FRAME, 32'd0);
    endtask

    // Zero capacity overflows everything; zero alignment acts as one
    task automatic test_zero_capacity();
        set_ring(32'd0, 32'd0);
        send_request(OP_ALLOC, 32'd0);
        send_request(OP_ALLOC, 32'd5);
        send_request(OP_FRAME, 32'd0);
    endtask

    // Cursor left past a capacity that was reduced afterwards
    task automatic test_shrunken_capacity();
        set_ring(32'd4096, 32'd64);
        send_request(OP_ALLOC, 32'd3000);
        send_request(OP_ALLOC, 32'd100);
        wait_idle();
        write_reg(REG_CAPACITY, 32'd1024);
        send_request(OP_ALLOC, 32'd10);
        send_request(OP_ALLOC, 32'd2000);
        send_request(OP_FRAME, 32'd0);
    endtask

    // Receiver holds off while requests keep coming, so the block backs up
    task automatic test_full_stall();
        set_ring(32'd65536, 32'd1);
        long_hold = 1'b1;
        repeat (14) send_request(OP_ALLOC, pick_request_size(cfg_capacity));
        wait_idle();
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: set_ring(32'd65536, 32'd1);
                1: set_ring(32'd1000, 32'd16);
                2: set_ring($urandom_range(1, 5000), $urandom_range(1, 300));
                3: set_ring(ALL_ONES, 32'd4096);
                4: set_ring(32'd3, 32'd1);
                5: set_ring($urandom(), $urandom());
                default: set_ring(32'd0, 32'd7);
            endcase
            run_random_items(phase == 6 ? 30 : 120);
        end
    endtask

    // Final stretch at full rate on both sides
    task automatic test_quiet_tail();
        quiet_tail = 1'b1;
        set_ring(32'd8192, 32'd8);
        run_random_items(120);
    endtask

    // Result side: random stall bursts and the long hold
    initial begin : result_drain
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (long_hold) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                long_hold = 1'b0;
            end else if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                pop <= 1'b0;
                stall_left = $urandom_range(1, 19) - 1;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk) begin : result_check
        t_result want;
        if (rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                flag_error("result transfer with nothing expected");
            end else begin
                want = pending_results.pop_front();
                check_field("granted", 64'(res.granted), 64'(want.granted));
                check_field("offset", 64'(res.offset), 64'(want.offset));
                check_field("aligned_bytes", 64'(res.aligned_bytes),
                            64'(want.aligned_bytes));
                check_field("wrapped", 64'(res.wrapped), 64'(want.wrapped));
                check_field("overflow_flag", 64'(res.overflow_flag),
                            64'(want.overflow_flag));
                check_field("peak_used", 64'(res.peak_used), 64'(want.peak_used));
                check_field("grant_count", 64'(res.grant_count), 64'(want.grant_count));
                check_field("wrap_total", 64'(res.wrap_total), 64'(want.wrap_total));
            end
            results_checked++;
        end
    end

    // Run limit
    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    // Test sequence
    initial begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_data        = '0;
        push            = 1'b0;
        req             = '0;
        pop             = 1'b0;
        quiet_tail      = 1'b0;
        long_hold       = 1'b0;
        mismatch_count  = 0;
        results_checked = 0;
        cfg_capacity    = 64'(CAPACITY_RST);
        cfg_alignment   = 64'(ALIGNMENT_RST);
        ring_cursor     = '0;
        ring_peak       = '0;
        frame_grants    = '0;
        wrap_tally      = '0;
        overflow_seen   = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_settings();
        test_alignment_extremes();
        test_zero_capacity();
        test_shrunken_capacity();
        test_full_stall();
        test_random_phases();
        test_quiet_tail();
        wait_idle();

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
